>>> rtl/atpr_pkg.sv
// ----------------------------------------------------------------------------
// atpr_pkg
// Shared constants, widths and the arctangent table for the tilt pipeline.
// ----------------------------------------------------------------------------
package atpr_pkg;

  // CORDIC iteration count, capped at the table length
  localparam int CORDIC_STEPS = 16;
  localparam int TabLen       = 24;
  localparam int CordicN      = (CORDIC_STEPS > TabLen) ? TabLen : CORDIC_STEPS;

  // datapath widths
  localparam int XW      = 38;  // CORDIC x/y
  localparam int AW      = 26;  // angle, 2^-15 degree units
  localparam int SqInW   = 28;  // sum of squares
  localparam int RootW   = 30;  // isqrt(v << 32)
  localparam int RemW    = 62;  // square root remainder
  localparam int SqrtLat = RootW;

  // scale and angle constants
  localparam logic signed [18:0] ACC_K     = 19'sd160672;
  localparam logic signed [AW-1:0] HALF_TURN = 26'sd5898240;
  localparam int PITCH_LIM = 23040;
  localparam int ROLL_LIM  = 11520;

  // pipeline depth in register stages, input stage through result register
  localparam int LAST = 3 + SqrtLat + CordicN;

  localparam logic [20:0] ATAN_TAB [TabLen] = '{
    21'd1474560, 21'd870484, 21'd459940, 21'd233473, 21'd117189, 21'd58652,
    21'd29333,   21'd14667,  21'd7334,   21'd3667,   21'd1833,   21'd917,
    21'd458,     21'd229,    21'd115,    21'd57,     21'd29,     21'd14,
    21'd7,       21'd4,      21'd2,      21'd1,      21'd0,      21'd0
  };

endpackage

>>> rtl/atpr_sqrt.sv
// ----------------------------------------------------------------------------
// atpr_sqrt
// Pipelined digit-by-digit square root: floor(sqrt(v << 32)), one bit a stage.
// ----------------------------------------------------------------------------
module atpr_sqrt
  import atpr_pkg::*;
(
  input  logic             clk_i,
  input  logic             en_i,
  input  logic [SqInW-1:0] v_i,
  output logic [RootW-1:0] root_o
);

  logic [RemW-1:0]  rem_q  [RootW];
  logic [RootW-1:0] root_q [RootW];

  for (genvar j = 0; j < RootW; j++) begin : g_stage
    localparam int K = RootW - 1 - j;
    logic [RemW-1:0]  rem_src;
    logic [RootW-1:0] root_src;
    logic [RemW-1:0]  trial;

    if (j == 0) begin : g_first
      assign rem_src  = {{(RemW - SqInW - 32){1'b0}}, v_i, 32'd0};
      assign root_src = '0;
    end else begin : g_next
      assign rem_src  = rem_q[j-1];
      assign root_src = root_q[j-1];
    end

    // (q + 2^k)^2 - q^2
    assign trial = ({{(RemW - RootW){1'b0}}, root_src} << (K + 1))
                 + ({{(RemW - 1){1'b0}}, 1'b1} << (2 * K));

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        if (rem_src >= trial) begin
          rem_q[j]  <= rem_src - trial;
          root_q[j] <= root_src | (RootW'(1) << K);
        end else begin
          rem_q[j]  <= rem_src;
          root_q[j] <= root_src;
        end
      end
    end
  end

  assign root_o = root_q[RootW-1];

endmodule

>>> rtl/atpr_cordic.sv
// ----------------------------------------------------------------------------
// atpr_cordic
// Pipelined vectoring CORDIC, one iteration a stage; angle starts at a_i.
// ----------------------------------------------------------------------------
module atpr_cordic
  import atpr_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 en_i,
  input  logic signed [XW-1:0] x_i,
  input  logic signed [XW-1:0] y_i,
  input  logic signed [AW-1:0] a_i,
  output logic signed [AW-1:0] a_o
);

  logic signed [XW-1:0] x_q [CordicN];
  logic signed [XW-1:0] y_q [CordicN];
  logic signed [AW-1:0] a_q [CordicN];

  for (genvar i = 0; i < CordicN; i++) begin : g_iter
    logic signed [XW-1:0] x_src, y_src, xs, ys;
    logic signed [AW-1:0] a_src, step;

    if (i == 0) begin : g_first
      assign x_src = x_i;
      assign y_src = y_i;
      assign a_src = a_i;
    end else begin : g_next
      assign x_src = x_q[i-1];
      assign y_src = y_q[i-1];
      assign a_src = a_q[i-1];
    end

    assign xs   = x_src >>> i;
    assign ys   = y_src >>> i;
    assign step = $signed({{(AW - 21){1'b0}}, ATAN_TAB[i]});

    // rotate toward the x axis
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        if (y_src > 0) begin
          x_q[i] <= x_src + ys;
          y_q[i] <= y_src - xs;
          a_q[i] <= a_src + step;
        end else begin
          x_q[i] <= x_src - ys;
          y_q[i] <= y_src + xs;
          a_q[i] <= a_src - step;
        end
      end
    end
  end

  assign a_o = a_q[CordicN-1];

endmodule

>>> rtl/accel_tilt_pitch_roll.sv
// ----------------------------------------------------------------------------
// accel_tilt_pitch_roll
// Scales one three-axis sample and derives magnitude, pitch and roll.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel: in_valid_i / in_stall_o with raw_x_i, raw_y_i, raw_z_i.
//   Output channel: out_valid_o / out_stall_i with the scaled axes, the
//   magnitude, pitch, roll and the zero_vector flag, one result per item.
//   The pipeline is LAST = 3 + 30 + CORDIC_STEPS register stages deep (49 at
//   16 steps): two scaling stages, a 30-stage bit-per-stage square root for
//   |a| and for the horizontal length, the roll CORDIC, one iteration a
//   stage, and the result register.
//   Pitch runs its CORDIC alongside and waits in a delay line.
//   Throughput is one item per cycle. The whole pipeline advances together;
//   it holds when the result register is full and out_stall_i is high, and
//   in_stall_o is raised in that case, so nothing is lost or repeated.
//   Reset clears all valid bits; the pipeline holds no other state.
// ----------------------------------------------------------------------------
module accel_tilt_pitch_roll
  import atpr_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic signed [15:0] raw_x_i,
  input  logic signed [15:0] raw_y_i,
  input  logic signed [15:0] raw_z_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic signed [15:0] accel_x_o,
  output logic signed [15:0] accel_y_o,
  output logic signed [15:0] accel_z_o,
  output logic        [15:0] magnitude_o,
  output logic signed [15:0] pitch_deg_o,
  output logic signed [14:0] roll_deg_o,
  output logic               zero_vector_o
);

  localparam int AxDly    = LAST - 3;
  localparam int ZeroDly  = LAST - 2;
  localparam int PitchDly = LAST - 2 - CordicN;
  localparam int SyDly    = SqrtLat + 1;
  localparam int MagDly   = LAST - 35;

  logic en;
  logic v_q [LAST];

  // global advance
  assign en         = !v_q[LAST-1] || !out_stall_i;
  assign in_stall_o = !en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < LAST; i++) v_q[i] <= 1'b0;
    end else if (en) begin
      v_q[0] <= in_valid_i;
      for (int i = 1; i < LAST; i++) v_q[i] <= v_q[i-1];
    end
  end

  // stage 1: 14-bit axes, scale products, squares
  logic signed [13:0] sx_d, sy_d, sz_d;
  logic signed [13:0] s1_sx_q, s1_sy_q, s1_sz_q;
  logic signed [32:0] s1_px_q, s1_py_q, s1_pz_q;
  logic signed [27:0] qx_d, qy_d, qz_d;
  logic        [26:0] s1_qx_q, s1_qy_q, s1_qz_q;
  logic               s1_zero_q;

  assign sx_d = 14'(raw_x_i >>> 2);
  assign sy_d = 14'(raw_y_i >>> 2);
  assign sz_d = 14'(raw_z_i >>> 2);
  assign qx_d = sx_d * sx_d;
  assign qy_d = sy_d * sy_d;
  assign qz_d = sz_d * sz_d;

  always_ff @(posedge clk_i) begin
    if (en) begin
      s1_sx_q   <= sx_d;
      s1_sy_q   <= sy_d;
      s1_sz_q   <= sz_d;
      s1_px_q   <= 33'(sx_d) * 33'(ACC_K);
      s1_py_q   <= 33'(sy_d) * 33'(ACC_K);
      s1_pz_q   <= 33'(sz_d) * 33'(ACC_K);
      s1_qx_q   <= qx_d[26:0];
      s1_qy_q   <= qy_d[26:0];
      s1_qz_q   <= qz_d[26:0];
      s1_zero_q <= (sx_d == 14'sd0) && (sy_d == 14'sd0) && (sz_d == 14'sd0);
    end
  end

  // stage 2: rounded axes, sums of squares
  logic signed [32:0] rx, ry, rz;
  logic signed [15:0] s2_ax_q, s2_ay_q, s2_az_q;
  logic [SqInW-1:0]   s2_sxz_q, s2_sum_q;
  logic [SqInW-1:0]   sxz_d;

  assign rx    = (s1_px_q + 33'sd32768) >>> 16;
  assign ry    = (s1_py_q + 33'sd32768) >>> 16;
  assign rz    = (s1_pz_q + 33'sd32768) >>> 16;
  assign sxz_d = SqInW'(s1_qx_q) + SqInW'(s1_qz_q);

  always_ff @(posedge clk_i) begin
    if (en) begin
      s2_ax_q  <= rx[15:0];
      s2_ay_q  <= ry[15:0];
      s2_az_q  <= rz[15:0];
      s2_sxz_q <= sxz_d;
      s2_sum_q <= sxz_d + SqInW'(s1_qy_q);
    end
  end

  // pitch: fold to x >= 0, then CORDIC
  logic signed [XW-1:0] px0, py0;
  logic signed [AW-1:0] pa0, pitch_ang;

  always_comb begin
    if (s1_sz_q < 0) begin
      px0 = (-XW'(s1_sz_q)) <<< 20;
      py0 = -(XW'(s1_sx_q) <<< 20);
      pa0 = (s1_sx_q >= 0) ? HALF_TURN : -HALF_TURN;
    end else begin
      px0 = XW'(s1_sz_q) <<< 20;
      py0 = XW'(s1_sx_q) <<< 20;
      pa0 = '0;
    end
  end

  atpr_cordic u_pitch (
    .clk_i (clk_i),
    .en_i  (en),
    .x_i   (px0),
    .y_i   (py0),
    .a_i   (pa0),
    .a_o   (pitch_ang)
  );

  // square roots of |a|^2 and x^2 + z^2
  logic [RootW-1:0] mag_root, h_root;

  atpr_sqrt u_sqrt_mag (
    .clk_i  (clk_i),
    .en_i   (en),
    .v_i    (s2_sum_q),
    .root_o (mag_root)
  );

  atpr_sqrt u_sqrt_h (
    .clk_i  (clk_i),
    .en_i   (en),
    .v_i    (s2_sxz_q),
    .root_o (h_root)
  );

  // roll: CORDIC on (h, y)
  logic signed [13:0]   sy_dly_q [SyDly];
  logic signed [XW-1:0] rx0, ry0;
  logic signed [AW-1:0] roll_ang;

  always_ff @(posedge clk_i) begin
    if (en) begin
      sy_dly_q[0] <= s1_sy_q;
      for (int i = 1; i < SyDly; i++) sy_dly_q[i] <= sy_dly_q[i-1];
    end
  end

  // h = isqrt(sxz << 16) = isqrt(sxz << 32) >> 8
  assign rx0 = $signed(XW'(h_root >> 8) << 12);
  assign ry0 = XW'(sy_dly_q[SyDly-1]) <<< 20;

  atpr_cordic u_roll (
    .clk_i (clk_i),
    .en_i  (en),
    .x_i   (rx0),
    .y_i   (ry0),
    .a_i   ('0),
    .a_o   (roll_ang)
  );

  // magnitude scale, round, saturate
  logic [47:0] mag_prod_q;
  logic [47:0] mag_rnd;
  logic [15:0] mag_q;

  assign mag_rnd = (mag_prod_q + 48'h0000_8000_0000) >> 32;

  always_ff @(posedge clk_i) begin
    if (en) begin
      mag_prod_q <= 48'(mag_root) * 48'(ACC_K);
      mag_q      <= (mag_rnd > 48'hFFFF) ? 16'hFFFF : mag_rnd[15:0];
    end
  end

  // delay lines to the result stage
  logic signed [15:0]   ax_dly_q [AxDly];
  logic signed [15:0]   ay_dly_q [AxDly];
  logic signed [15:0]   az_dly_q [AxDly];
  logic                 zero_dly_q [ZeroDly];
  logic signed [AW-1:0] pitch_dly_q [PitchDly];
  logic [15:0]          mag_dly_q [MagDly];

  always_ff @(posedge clk_i) begin
    if (en) begin
      ax_dly_q[0]    <= s2_ax_q;
      ay_dly_q[0]    <= s2_ay_q;
      az_dly_q[0]    <= s2_az_q;
      zero_dly_q[0]  <= s1_zero_q;
      pitch_dly_q[0] <= pitch_ang;
      mag_dly_q[0]   <= mag_q;
      for (int i = 1; i < AxDly; i++) begin
        ax_dly_q[i] <= ax_dly_q[i-1];
        ay_dly_q[i] <= ay_dly_q[i-1];
        az_dly_q[i] <= az_dly_q[i-1];
      end
      for (int i = 1; i < ZeroDly; i++) zero_dly_q[i] <= zero_dly_q[i-1];
      for (int i = 1; i < PitchDly; i++) pitch_dly_q[i] <= pitch_dly_q[i-1];
      for (int i = 1; i < MagDly; i++) mag_dly_q[i] <= mag_dly_q[i-1];
    end
  end

  // angle rounding to 1/128 degree and clamping
  logic signed [AW-1:0] p_rnd, r_rnd;
  logic signed [AW-1:0] p_neg;
  logic signed [15:0]   pitch_d;
  logic signed [14:0]   roll_d;
  logic                 zero_f;

  assign zero_f = zero_dly_q[ZeroDly-1];
  assign p_rnd  = (pitch_dly_q[PitchDly-1] + AW'(128)) >>> 8;
  assign r_rnd  = (roll_ang + AW'(128)) >>> 8;
  assign p_neg  = -p_rnd;

  always_comb begin
    if (zero_f) begin
      pitch_d = '0;
    end else if (p_neg > AW'(PITCH_LIM)) begin
      pitch_d = 16'(PITCH_LIM);
    end else if (p_neg < -AW'(PITCH_LIM)) begin
      pitch_d = -16'(PITCH_LIM);
    end else begin
      pitch_d = p_neg[15:0];
    end

    if (zero_f) begin
      roll_d = '0;
    end else if (r_rnd > AW'(ROLL_LIM)) begin
      roll_d = 15'(ROLL_LIM);
    end else if (r_rnd < -AW'(ROLL_LIM)) begin
      roll_d = -15'(ROLL_LIM);
    end else begin
      roll_d = r_rnd[14:0];
    end
  end

  // result register
  always_ff @(posedge clk_i) begin
    if (en) begin
      accel_x_o     <= ax_dly_q[AxDly-1];
      accel_y_o     <= ay_dly_q[AxDly-1];
      accel_z_o     <= az_dly_q[AxDly-1];
      magnitude_o   <= mag_dly_q[MagDly-1];
      pitch_deg_o   <= pitch_d;
      roll_deg_o    <= roll_d;
      zero_vector_o <= zero_f;
    end
  end

  assign out_valid_o = v_q[LAST-1];

endmodule

>>> test/tb_accel_tilt_pitch_roll.sv
// ----------------------------------------------------------------------------
// tb_accel_tilt_pitch_roll
// Drives raw three-axis samples through the tilt pipeline and checks the
// scaled axes, magnitude, pitch, roll and zero flag against an in-bench
// fixed-point predictor, with random bursts on the input and random stalls
// on the output.
// ----------------------------------------------------------------------------
module tb_accel_tilt_pitch_roll;
  import atpr_pkg::*;

  typedef struct packed {
    logic signed [15:0] ax;
    logic signed [15:0] ay;
    logic signed [15:0] az;
    logic        [15:0] mag;
    logic signed [15:0] pitch;
    logic signed [14:0] roll;
    logic               zero;
  } tilt_t;

  localparam longint KSCALE   = 160672;
  localparam longint HALFTURN = 5898240;
  localparam longint TURN_TAB [24] = '{
    1474560, 870484, 459940, 233473, 117189, 58652, 29333, 14667,
    7334, 3667, 1833, 917, 458, 229, 115, 57, 29, 14, 7, 4, 2, 1, 0, 0};
  localparam int STEPS = (CORDIC_STEPS > 24) ? 24 : CORDIC_STEPS;
  localparam longint CYCLE_LIMIT = 400000;

  logic               clk_i;
  logic               rst_ni;
  logic               in_valid_i;
  logic               in_stall_o;
  logic signed [15:0] raw_x_i, raw_y_i, raw_z_i;
  logic               out_valid_o;
  logic               out_stall_i;
  logic signed [15:0] accel_x_o, accel_y_o, accel_z_o;
  logic        [15:0] magnitude_o;
  logic signed [15:0] pitch_deg_o;
  logic signed [14:0] roll_deg_o;
  logic               zero_vector_o;

  tilt_t  tilt_q[$];
  int     err_cnt = 0;
  int     sent_cnt;
  int     got_cnt = 0;
  longint cyc_cnt = 0;

  accel_tilt_pitch_roll u_top (.*);

  // clock
  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // timeout
  always @(posedge clk_i) begin
    cyc_cnt <= cyc_cnt + 1;
    if (cyc_cnt > CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // square root of a 64-bit value, truncated
  function automatic longint unsigned isqrt(longint unsigned v);
    longint unsigned res, bitv;
    res  = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv >>= 2;
    while (bitv != 0) begin
      if (v >= res + bitv) begin
        v  -= res + bitv;
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return res;
  endfunction

  // vectoring rotation, angle in 2^-15 degree
  function automatic longint vec_angle(longint x, longint y);
    longint a, xs, ys;
    a = 0;
    for (int i = 0; i < STEPS; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (y > 0) begin
        x += ys; y -= xs; a += TURN_TAB[i];
      end else begin
        x -= ys; y += xs; a -= TURN_TAB[i];
      end
    end
    return a;
  endfunction

  function automatic longint clip(longint v, longint lim);
    return (v > lim) ? lim : ((v < -lim) ? -lim : v);
  endfunction

  function automatic tilt_t predict_tilt(logic signed [15:0] rx, ry, rz);
    tilt_t  t;
    longint sx, sy, sz, ang, h, p, r;
    longint unsigned sxz, rt, mg;
    sx = longint'(rx) >>> 2;
    sy = longint'(ry) >>> 2;
    sz = longint'(rz) >>> 2;
    t.ax = 16'((sx * KSCALE + 32768) >>> 16);
    t.ay = 16'((sy * KSCALE + 32768) >>> 16);
    t.az = 16'((sz * KSCALE + 32768) >>> 16);
    sxz = sx * sx + sz * sz;
    rt  = isqrt((sxz + sy * sy) << 32);
    mg  = (rt * KSCALE + (64'd1 << 31)) >> 32;
    t.mag  = (mg > 64'hFFFF) ? 16'hFFFF : 16'(mg);
    t.zero = (sx == 0 && sy == 0 && sz == 0);
    p = 0;
    r = 0;
    if (!t.zero) begin
      if (sz < 0)
        ang = ((sx >= 0) ? HALFTURN : -HALFTURN) + vec_angle(-sz * 1048576, -sx * 1048576);
      else
        ang = vec_angle(sz * 1048576, sx * 1048576);
      p   = clip(-((ang + 128) >>> 8), PITCH_LIM);
      h   = longint'(isqrt(sxz << 16));
      ang = vec_angle(h * 4096, sy * 256 * 4096);
      r   = clip((ang + 128) >>> 8, ROLL_LIM);
    end
    t.pitch = 16'(p);
    t.roll  = 15'(r);
    return t;
  endfunction

  // output stall pattern: long free stretches and random busy spells
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else if (cyc_cnt % 600 < 150) begin
      out_stall_i <= 1'b0;
    end else begin
      out_stall_i <= ($urandom_range(0, 3) == 0);
    end
  end

  // result checker
  always @(posedge clk_i) begin
    tilt_t e;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      got_cnt <= got_cnt + 1;
      if (tilt_q.size() == 0) begin
        $error("result with no item pending");
        err_cnt <= err_cnt + 1;
      end else begin
        e = tilt_q.pop_front();
        if (accel_x_o !== e.ax) begin
          $error("accel_x exp %0d got %0d", e.ax, accel_x_o); err_cnt <= err_cnt + 1;
        end
        if (accel_y_o !== e.ay) begin
          $error("accel_y exp %0d got %0d", e.ay, accel_y_o); err_cnt <= err_cnt + 1;
        end
        if (accel_z_o !== e.az) begin
          $error("accel_z exp %0d got %0d", e.az, accel_z_o); err_cnt <= err_cnt + 1;
        end
        if (magnitude_o !== e.mag) begin
          $error("magnitude exp %0d got %0d", e.mag, magnitude_o); err_cnt <= err_cnt + 1;
        end
        if (pitch_deg_o !== e.pitch) begin
          $error("pitch_deg exp %0d got %0d", e.pitch, pitch_deg_o); err_cnt <= err_cnt + 1;
        end
        if (roll_deg_o !== e.roll) begin
          $error("roll_deg exp %0d got %0d", e.roll, roll_deg_o); err_cnt <= err_cnt + 1;
        end
        if (zero_vector_o !== e.zero) begin
          $error("zero_vector exp %0d got %0d", e.zero, zero_vector_o);
          err_cnt <= err_cnt + 1;
        end
      end
    end
  end

  // send one sample; expectation is queued at the accepting edge.
  // Without hold, valid drops for one idle cycle after the item.
  task automatic send_sample(logic signed [15:0] x, y, z, bit hold);
    in_valid_i <= 1'b1;
    raw_x_i    <= x;
    raw_y_i    <= y;
    raw_z_i    <= z;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    tilt_q.push_back(predict_tilt(x, y, z));
    sent_cnt++;
    if (!hold) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
  endtask

  task automatic test_corners();
    logic signed [15:0] v [8] = '{16'sh7FFF, -16'sh8000, 16'sd0, 16'sd3, -16'sd1,
                                  16'sd4, -16'sd4, 16'sh5555};
    // zero vector from raw words 0..3
    send_sample(16'sd0, 16'sd0, 16'sd0, 0);
    send_sample(16'sd3, 16'sd2, 16'sd1, 1);
    // negative z with zero x, zero z with nonzero x, vertical y
    send_sample(16'sd0, 16'sd100, -16'sd4000, 1);
    send_sample(16'sd4000, 16'sd0, 16'sd0, 0);
    send_sample(-16'sd4000, 16'sd0, 16'sd0, 1);
    send_sample(16'sd0, 16'sh7FFF, 16'sd0, 1);
    send_sample(16'sd0, -16'sh8000, 16'sd0, 0);
    for (int i = 0; i < 16; i++)
      send_sample(v[i % 8], v[(i * 3 + 1) % 8], v[(i * 5 + 2) % 8], i[0] && (i != 15));
  endtask

  task automatic test_random(int n);
    int left;
    logic signed [15:0] x, y, z;
    left = n;
    while (left > 0) begin
      int burst;
      burst = $urandom_range(1, 30);
      for (int b = 0; b < burst && left > 0; b++, left--) begin
        case ($urandom_range(0, 3))
          0: begin x = $urandom; y = $urandom; z = $urandom; end
          1: begin   // near-level, realistic 1 g range
            x = $urandom_range(0, 1000) - 500;
            y = $urandom_range(0, 1000) - 500;
            z = ($urandom_range(0, 1) ? 16'sd4096 : -16'sd4096) + x;
          end
          2: begin   // tiny values around the zero vector
            x = $urandom_range(0, 15) - 8;
            y = $urandom_range(0, 15) - 8;
            z = $urandom_range(0, 15) - 8;
          end
          default: begin   // each axis independently zero or random
            x = $urandom_range(0, 1) ? 16'sd0 : 16'($urandom);
            y = $urandom_range(0, 1) ? 16'sd0 : 16'($urandom);
            z = $urandom_range(0, 1) ? 16'sd0 : 16'($urandom);
          end
        endcase
        send_sample(x, y, z, (b + 1 < burst) && (left > 1));
      end
      repeat ($urandom_range(0, 8)) @(posedge clk_i);
    end
  endtask

  initial begin
    int drain;
    sent_cnt = 0;
    rst_ni     = 1'b0;
    in_valid_i = 1'b0;
    raw_x_i    = '0;
    raw_y_i    = '0;
    raw_z_i    = '0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_corners();
    test_random(900);
    while (tilt_q.size() != 0) @(posedge clk_i);
    drain = 0;
    while (drain < 4 * LAST) begin
      @(posedge clk_i);
      drain++;
    end
    $display("Sent %0d samples (corners, level tilts, near-zero, axis-zero, full range),",
             sent_cnt);
    $display("checked %0d results under random input gaps and output stalls.", got_cnt);
    if (err_cnt == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
